// ----- src/nmf_pkg.sv -----
// Shared types and constants for the 3x3 neighbour-mean filter.
// Used by every module of the block but nmf_line_ram; depends on nothing.

package nmf_pkg;

	// Pixel and channel geometry
	localparam int ChanW = 8;
	localparam int NumChan = 3;
	localparam int PixW = ChanW * NumChan;

	// Configuration registers
	localparam int CfgW = 16;
	localparam int FrameWidthW = 11;
	localparam int FrameHeightW = 16;
	localparam logic [FrameWidthW-1:0] WidthReset = 11'd640;
	localparam logic [FrameHeightW-1:0] HeightReset = 16'd480;
	localparam int MinDim = 3;

	// Line store depth default
	localparam int DefMaxWidth = 1024;

	// Register indexes on the configuration port
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// Item kinds carried in tuser
	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_DRAIN = 1'b1
	} action_t;

	typedef logic [PixW-1:0] pixel_t;

	// Per-item control decided when the item is taken in
	typedef struct packed {
		logic is_pixel;  // pixel item (else drain)
		logic emit;      // item produces a result
		logic interior;  // result is the neighbour mean
		logic last;      // result closes the frame
		logic col_zero;  // pixel sits in column zero
		logic sel_mid;   // drain reads the middle line (else upper)
	} item_ctl_t;

endpackage

// ----- src/nmf_line_ram.sv -----
// Line store memory: one write port, two registered read ports.
// Holds the upper and middle lines side by side; does not use nmf_pkg.

module nmf_line_ram #(
	parameter int Depth = 1024,
	parameter int AddrW = 10,
	parameter int DataW = 48
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [DataW-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr_a,
	input  logic [AddrW-1:0] raddr_b,
	output logic [DataW-1:0] rdata_a,
	output logic [DataW-1:0] rdata_b
);

	logic [DataW-1:0] mem [Depth];

	// Write and registered reads; a read at the written address returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- src/nmf_ctrl.sv -----
// Raster position tracking for the filter: input and output row/column counters.
// Decides per item what it does; depends on nmf_pkg.

module nmf_ctrl #(
	parameter int MAX_WIDTH = nmf_pkg::DefMaxWidth,
	localparam int ColW = $clog2(MAX_WIDTH),
	localparam int WdW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [nmf_pkg::FrameWidthW-1:0]     frame_width,
	input  logic [nmf_pkg::FrameHeightW-1:0]    frame_height,
	input  logic                                accept,
	input  logic                                drain,
	output nmf_pkg::item_ctl_t                  ctl,
	output logic                                live,
	output logic [ColW-1:0]                     rd_addr,
	output logic [ColW-1:0]                     edge_addr
);

	import nmf_pkg::*;

	localparam int CmpW = (WdW > FrameWidthW) ? WdW : FrameWidthW;
	localparam int RowW = FrameHeightW;

	logic [RowW-1:0] in_row_q, out_row_q;
	logic [ColW-1:0] in_col_q, out_col_q;

	logic [CmpW-1:0] fw_ext;
	logic [WdW-1:0]  w_eff, w_last, in_col_x, out_col_x;
	logic [WdW:0]    out_col_p2;
	logic [RowW-1:0] h_eff, in_row_nx;
	logic [RowW:0]   out_row_p1, out_row_p2;
	logic            in_done, col_wrap, due, out_col_wrap, out_row_last, in_done_nx;
	logic            rewind;
	logic [ColW-1:0] pix_idx, drn_idx;

	// Effective frame size
	always_comb begin
		fw_ext = CmpW'(frame_width);
		if (fw_ext < CmpW'(MinDim)) begin
			w_eff = WdW'(MinDim);
		end else if (fw_ext > CmpW'(MAX_WIDTH)) begin
			w_eff = WdW'(MAX_WIDTH);
		end else begin
			w_eff = WdW'(fw_ext);
		end
	end
	assign h_eff  = (frame_height < RowW'(MinDim)) ? RowW'(MinDim) : frame_height;
	assign w_last = w_eff - WdW'(1);

	// Input side position
	assign in_col_x  = WdW'(in_col_q);
	assign in_done   = in_row_q >= h_eff;
	assign col_wrap  = (in_col_x + WdW'(1)) >= w_eff;
	assign pix_idx   = (in_col_x < w_eff) ? in_col_q : ColW'(w_last);
	assign due       = (in_row_q >= RowW'(2)) || ((in_row_q == RowW'(1)) && (in_col_q != '0));
	assign in_row_nx = col_wrap ? (in_row_q + RowW'(1)) : in_row_q;

	// Output side position
	assign out_col_x    = WdW'(out_col_q);
	assign out_col_p2   = (WdW+1)'(out_col_q) + (WdW+1)'(2);
	assign out_row_p1   = (RowW+1)'(out_row_q) + (RowW+1)'(1);
	assign out_row_p2   = (RowW+1)'(out_row_q) + (RowW+1)'(2);
	assign out_col_wrap = (out_col_x + WdW'(1)) >= w_eff;
	assign out_row_last = out_row_p1 >= (RowW+1)'(h_eff);
	assign drn_idx      = (out_col_x < w_eff) ? out_col_q : ColW'(w_last);

	// Item decisions
	always_comb begin
		ctl.is_pixel = !drain;
		ctl.emit     = drain ? 1'b1 : due;
		ctl.interior = (out_row_q != '0) && (out_row_p2 <= (RowW+1)'(h_eff)) &&
			(out_col_q != '0) && (out_col_p2 <= (WdW+1)'(w_eff));
		ctl.last     = out_col_wrap && out_row_last;
		ctl.col_zero = in_col_q == '0;
		ctl.sel_mid  = out_row_last;
	end
	assign live       = drain ? in_done : !in_done;
	assign in_done_nx = drain ? 1'b1 : (in_row_nx >= h_eff);
	assign rewind     = ctl.emit && ctl.last && in_done_nx;
	assign rd_addr    = drain ? drn_idx : pix_idx;
	assign edge_addr  = ColW'(w_last);

	// Counter updates; a frame close rewinds the input side once it is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (accept && live) begin
			if (rewind) begin
				in_row_q <= '0;
				in_col_q <= '0;
			end else if (!drain) begin
				in_col_q <= col_wrap ? '0 : in_col_q + ColW'(1);
				in_row_q <= in_row_nx;
			end
			if (ctl.emit) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					if (out_row_last) begin
						out_row_q <= '0;
					end else begin
						out_row_q <= out_row_q + RowW'(1);
					end
				end else begin
					out_col_q <= out_col_q + ColW'(1);
				end
			end
		end
	end

	// A frame close leaves the output position at the frame origin
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && live && ctl.emit && ctl.last |=> out_row_q == '0 && out_col_q == '0)
		else $error("output position not rewound after frame end");

	// An early drain moves nothing
	a_early_drain: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drain && !in_done |=> $stable(out_row_q) && $stable(out_col_q))
		else $error("ignored drain moved output position");

	// A pixel after frame input is complete moves nothing
	a_late_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !drain && in_done |=> $stable(in_row_q) && $stable(in_col_q))
		else $error("dropped pixel moved input position");

endmodule

// ----- src/nmf_window.sv -----
// 3x3 window columns and the neighbour-mean / pass-through result select.
// Depends on nmf_pkg.

module nmf_window (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  nmf_pkg::pixel_t up_px,
	input  nmf_pkg::pixel_t mid_px,
	input  nmf_pkg::pixel_t in_px,
	input  nmf_pkg::pixel_t edge_px,
	input  logic            interior,
	input  logic            col_zero,
	output nmf_pkg::pixel_t value
);

	import nmf_pkg::*;

	localparam int SumW = ChanW + 3;

	// Two older window columns; the newest column is read straight from the inputs
	pixel_t col1_q [3];
	pixel_t col2_q [3];
	pixel_t mean;
	logic [SumW-1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				col1_q[r] <= '0;
				col2_q[r] <= '0;
			end
		end else if (shift) begin
			col1_q    <= col2_q;
			col2_q[0] <= up_px;
			col2_q[1] <= mid_px;
			col2_q[2] <= in_px;
		end
	end

	// Sum of the eight neighbours of the shifted window, per channel, then /8
	always_comb begin
		mean = '0;
		for (int k = 0; k < NumChan; k++) begin
			sum = SumW'(col1_q[0][k*ChanW +: ChanW]) + SumW'(col2_q[0][k*ChanW +: ChanW]) +
				SumW'(up_px[k*ChanW +: ChanW]) + SumW'(col1_q[1][k*ChanW +: ChanW]) +
				SumW'(mid_px[k*ChanW +: ChanW]) + SumW'(col1_q[2][k*ChanW +: ChanW]) +
				SumW'(col2_q[2][k*ChanW +: ChanW]) + SumW'(in_px[k*ChanW +: ChanW]);
			mean[k*ChanW +: ChanW] = sum[SumW-1:3];
		end
	end

	// Border pixels pass through; in column zero the centre is the right edge pixel
	always_comb begin
		if (interior) begin
			value = mean;
		end else if (col_zero) begin
			value = edge_px;
		end else begin
			value = col2_q[1];
		end
	end

endmodule

// ----- src/neighbour_mean_filter_3x3_unit.sv -----
// Top level of the 3x3 neighbour-mean filter: ports, stage-1 and output registers.
// Instantiates nmf_ctrl, nmf_line_ram and nmf_window; depends on nmf_pkg.

// Takes one item per clock and keeps that rate as long as results are taken. An item
// is taken in (counters step and the line store read is issued), computed in stage 1
// against the registered read data and the window, and lands in the output register
// when stage 1 moves on. Results trail the pixels by one row plus one pixel, so after
// the last pixel of a frame, frame_width + 1 drain items (tuser high) push out the tail;
// the last result of a frame has tlast. Pixels sent after a frame's input is complete
// are dropped until the drain closes the frame, and drains sent before that are ignored.
// Line store contents are undefined after reset; no clearing pass is run. Write
// frame_width and frame_height only while the block holds no item in flight.

module neighbour_mean_filter_3x3_unit #(
	parameter int MAX_WIDTH = nmf_pkg::DefMaxWidth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [nmf_pkg::CfgW-1:0]   cfg_data,
	// input stream
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [nmf_pkg::PixW-1:0]   s_axis_tdata,   // in_blue, in_green, in_red
	input  logic                       s_axis_tuser,   // action
	// output stream
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [nmf_pkg::PixW-1:0]   m_axis_tdata,   // out_blue, out_green, out_red
	output logic                       m_axis_tlast    // frame_end
);

	import nmf_pkg::*;

	localparam int ColW = $clog2(MAX_WIDTH);
	localparam int LineW = 2 * PixW;

	logic [FrameWidthW-1:0]  frame_width_q;
	logic [FrameHeightW-1:0] frame_height_q;

	logic            accept, live, drain;
	item_ctl_t       ctl;
	logic [ColW-1:0] rd_addr, edge_addr;

	logic            valid_s1, hit_a_s1, hit_e_s1;
	item_ctl_t       ctl_s1;
	pixel_t          pix_s1;
	logic [ColW-1:0] idx_s1;
	logic [LineW-1:0] fwd_s1;

	logic [LineW-1:0] rd_a, rd_b, wr_line;
	pixel_t          a_px, m_px, edge_px, win_value, result;
	logic            adv_s1, wr_now;

	logic            out_valid_q, out_last_q;
	pixel_t          out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WidthReset;
			frame_height_q <= HeightReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FrameWidthW-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FrameHeightW-1:0];
				default: ;
			endcase
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;
	assign drain  = s_axis_tuser == ACT_DRAIN;

	nmf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.accept       (accept),
		.drain        (drain),
		.ctl          (ctl),
		.live         (live),
		.rd_addr      (rd_addr),
		.edge_addr    (edge_addr)
	);

	// Stage 1 moves on when it makes no result or the output register frees up
	assign adv_s1        = valid_s1 && (!ctl_s1.emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign wr_now        = valid_s1 && ctl_s1.is_pixel;

	// Line word: upper line in the low half, middle line in the high half
	nmf_line_ram #(.Depth(MAX_WIDTH), .AddrW(ColW), .DataW(LineW)) u_lines (
		.clk     (clk),
		.we      (adv_s1 && ctl_s1.is_pixel),
		.waddr   (idx_s1),
		.wdata   (wr_line),
		.re      (accept),
		.raddr_a (rd_addr),
		.raddr_b (edge_addr),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Stage 1 register; catches the line write that lands on the same edge as the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_a_s1 <= 1'b0;
			hit_e_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= accept && live;
			hit_a_s1 <= wr_now && (idx_s1 == rd_addr);
			hit_e_s1 <= wr_now && (idx_s1 == edge_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
			pix_s1 <= s_axis_tdata;
			idx_s1 <= rd_addr;
			fwd_s1 <= wr_line;
		end
	end

	// Line store read data with bypass
	assign a_px    = hit_a_s1 ? fwd_s1[PixW-1:0] : rd_a[PixW-1:0];
	assign m_px    = hit_a_s1 ? fwd_s1[LineW-1:PixW] : rd_a[LineW-1:PixW];
	assign edge_px = hit_e_s1 ? fwd_s1[PixW-1:0] : rd_b[PixW-1:0];
	assign wr_line = {pix_s1, m_px};

	nmf_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (adv_s1 && ctl_s1.is_pixel),
		.up_px    (a_px),
		.mid_px   (m_px),
		.in_px    (pix_s1),
		.edge_px  (edge_px),
		.interior (ctl_s1.interior),
		.col_zero (ctl_s1.col_zero),
		.value    (win_value)
	);

	// Drains replay the delayed pixel straight from the line stores
	assign result = ctl_s1.is_pixel ? win_value : (ctl_s1.sel_mid ? m_px : a_px);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctl_s1.emit) begin
			out_data_q <= result;
			out_last_q <= ctl_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// Input stalls only behind a full, blocked output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && ctl_s1.emit && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// A bypass hit needs a line write from the item just ahead
	a_bypass_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (hit_a_s1 || hit_e_s1) && $past(s_axis_tready) |->
		$past(adv_s1 && ctl_s1.is_pixel))
		else $error("bypass hit without a preceding line write");

	// A result leaving stage 1 is presented next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && ctl_s1.emit |=> m_axis_tvalid)
		else $error("result lost between stage 1 and output");

endmodule
